// File: src/lpbm_pkg.sv
// ----------------------------------------------------------------------------
// lpbm_pkg
// Shared widths, codes, types and helpers for the LRU page buffer manager.
// ----------------------------------------------------------------------------
package lpbm_pkg;

	// Pool size and derived widths
	localparam int NUM_BUFFERS = 8;
	localparam int SLOT_W      = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int SLOT_IN_W   = 3;
	localparam int CMP_W       = (SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W;

	// Field widths
	localparam int ACTION_W = 3;
	localparam int REL_W    = 32;
	localparam int PAGE_W   = 31;
	localparam int KIND_W   = 2;

	// At most this many flush requests are reported per relation command
	localparam int MAX_FLUSH = 8;
	localparam int CNT_W     = $clog2(MAX_FLUSH + 1);

	// Free mark
	localparam logic [REL_W-1:0]  FREE_REL  = '1;
	localparam logic [PAGE_W-1:0] FREE_PAGE = '1;

	// Action codes
	typedef logic [ACTION_W-1:0] action_t;
	localparam action_t ACT_LOOKUP     = 3'd0;
	localparam action_t ACT_TOUCH      = 3'd1;
	localparam action_t ACT_FLUSH_REL  = 3'd2;
	localparam action_t ACT_RESET_REL  = 3'd3;
	localparam action_t ACT_RESET_SLOT = 3'd4;

	// Result kinds
	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_HIT   = 2'd0;
	localparam kind_t KIND_MISS  = 2'd1;
	localparam kind_t KIND_FLUSH = 2'd2;
	localparam kind_t KIND_ACK   = 2'd3;

	typedef logic [SLOT_W-1:0]      slot_id_t;
	typedef logic [NUM_BUFFERS-1:0] buf_mask_t;

	// One LRU position: buffer index and its tags
	typedef struct packed {
		slot_id_t          slot;
		logic [REL_W-1:0]  rel;
		logic [PAGE_W-1:0] page;
	} entry_t;

	// Compare results captured by a cell when a transaction is accepted
	typedef struct packed {
		logic hit;
		logic free;
		logic relm;
		logic posm;
	} cell_flags_t;

	// Per-cell commands from the sequencer
	typedef struct packed {
		logic cmp;
		logic shift;
		logic wr;
		logic clr;
	} cell_ctl_t;

	// Position of the set bit nearest the head
	function automatic slot_id_t first_set(input buf_mask_t m);
		slot_id_t r;
		r = '0;
		for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
			if (m[i]) r = SLOT_W'(i);
		end
		return r;
	endfunction

	// Position of the set bit nearest the tail
	function automatic slot_id_t last_set(input buf_mask_t m);
		slot_id_t r;
		r = '0;
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			if (m[i]) r = SLOT_W'(i);
		end
		return r;
	endfunction

	// Buffer index as reported on the result port (low three bits)
	function automatic logic [SLOT_IN_W-1:0] slot_to_out(input slot_id_t s);
		logic [SLOT_W+SLOT_IN_W-1:0] w;
		w = (SLOT_W + SLOT_IN_W)'(s);
		return w[SLOT_IN_W-1:0];
	endfunction

endpackage

// File: src/lpbm_if.sv
// ----------------------------------------------------------------------------
// lpbm_if
// Valid/ready channels of the LRU page buffer manager: command and result.
// ----------------------------------------------------------------------------
interface lpbm_req_if import lpbm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ACTION_W-1:0]  action;
	logic [REL_W-1:0]     relation_id;
	logic [PAGE_W-1:0]    page_id;
	logic [SLOT_IN_W-1:0] slot;

	modport source (output valid, action, relation_id, page_id, slot, input ready);
	modport sink   (input valid, action, relation_id, page_id, slot, output ready);
endinterface

interface lpbm_rsp_if import lpbm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [SLOT_IN_W-1:0] slot_out;
	logic                 last;

	modport source (output valid, kind, slot_out, last, input ready);
	modport sink   (input valid, kind, slot_out, last, output ready);
endinterface

// File: src/lru_page_buffer_manager.sv
// ----------------------------------------------------------------------------
// lru_page_buffer_manager
// Pool of page buffers kept in LRU order by a row of cells (head = MRU).
// Results: a command is latched on accept, evaluated in S_RUN, and its first
// result registered on the port; a relation flush/reset passes S_LIST first.
// A lookup that evicts the tail reports from S_RUN and then S_MISS; a
// relation flush/reset gives its k flushes one result per cycle from the list
// unless the result port stalls, ending with an ack. New commands wait for S_IDLE.
// Reset: all buffers free, slot i at position i; no clearing pass.
// ----------------------------------------------------------------------------
module lru_page_buffer_manager import lpbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lpbm_req_if.sink    req,
	lpbm_rsp_if.source  rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_MISS,
		S_LIST
	} state_t;

	state_t state_q, state_d;

	// Latched command
	action_t              act_q;
	logic [REL_W-1:0]     rel_q;
	logic [PAGE_W-1:0]    page_q;
	logic [SLOT_IN_W-1:0] slot_q;

	// Flush list walk
	buf_mask_t            list_q, list_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;

	// Result register
	logic                 out_valid_q;
	kind_t                kind_q;
	logic [SLOT_IN_W-1:0] slot_out_q;
	logic                 last_q;

	// Result being produced this cycle
	logic                 emit;
	kind_t                e_kind;
	logic [SLOT_IN_W-1:0] e_slot;
	logic                 e_last;

	logic                 accept;
	logic                 out_free;
	logic                 slot_in_range;

	entry_t               entries [NUM_BUFFERS];
	cell_flags_t          flags   [NUM_BUFFERS];
	cell_ctl_t            ctl     [NUM_BUFFERS];
	buf_mask_t            hit_m, free_m, relm_m, posm_m, above;
	entry_t               touch_e;
	slot_id_t             pos;

	assign accept        = req.valid && req.ready;
	assign out_free      = !out_valid_q || rsp.ready;
	assign slot_in_range = (32'(slot_q) < 32'(NUM_BUFFERS));

	// Row of cells
	for (genvar p = 0; p < NUM_BUFFERS; p++) begin : g_cell
		entry_t shift_in;
		if (p == 0) begin : g_head
			assign shift_in = touch_e;
		end else begin : g_body
			assign shift_in = entries[p-1];
		end

		lpbm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (SLOT_W'(p)),
			.ctl      (ctl[p]),
			.req_rel  (req.relation_id),
			.req_page (req.page_id),
			.req_slot (req.slot),
			.shift_in (shift_in),
			.wr_rel   (rel_q),
			.wr_page  (page_q),
			.entry    (entries[p]),
			.flags    (flags[p])
		);
	end

	// Gather flags; positions at or above the touched one shift toward tail
	always_comb begin
		for (int p = 0; p < NUM_BUFFERS; p++) begin
			hit_m[p]  = flags[p].hit;
			free_m[p] = flags[p].free;
			relm_m[p] = flags[p].relm;
			posm_m[p] = flags[p].posm;
		end
		above[NUM_BUFFERS-1] = posm_m[NUM_BUFFERS-1];
		for (int p = NUM_BUFFERS - 2; p >= 0; p--) begin
			above[p] = above[p+1] | posm_m[p];
		end
		touch_e = entries[0];
		for (int p = 0; p < NUM_BUFFERS; p++) begin
			if (posm_m[p]) touch_e = entries[p];
		end
	end

	// Sequencer decisions and cell commands
	always_comb begin
		state_d = state_q;
		list_d  = list_q;
		cnt_d   = cnt_q;
		emit    = 1'b0;
		e_kind  = KIND_ACK;
		e_slot  = '0;
		e_last  = 1'b1;
		pos     = '0;
		for (int p = 0; p < NUM_BUFFERS; p++) begin
			ctl[p]     = '0;
			ctl[p].cmp = accept;
		end

		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_RUN;
			end

			S_RUN: begin
				if (act_q == ACT_FLUSH_REL || act_q == ACT_RESET_REL) begin
					// capture the match list; reset frees all matches at once
					list_d  = relm_m;
					cnt_d   = '0;
					state_d = S_LIST;
					if (act_q == ACT_RESET_REL) begin
						for (int p = 0; p < NUM_BUFFERS; p++) ctl[p].clr = relm_m[p];
					end
				end else if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (act_q == ACT_LOOKUP) begin
						priority if (|hit_m) begin
							pos    = first_set(hit_m);
							e_kind = KIND_HIT;
							e_slot = slot_to_out(entries[pos].slot);
						end else if (|free_m) begin
							pos         = last_set(free_m);
							ctl[pos].wr = 1'b1;
							e_kind      = KIND_MISS;
							e_slot      = slot_to_out(entries[pos].slot);
						end else begin
							// evict tail: tags written now with the flush request, miss result next
							ctl[NUM_BUFFERS-1].wr = 1'b1;
							e_kind  = KIND_FLUSH;
							e_slot  = slot_to_out(entries[NUM_BUFFERS-1].slot);
							e_last  = 1'b0;
							state_d = S_MISS;
						end
					end else if (act_q == ACT_TOUCH) begin
						for (int p = 0; p < NUM_BUFFERS; p++) ctl[p].shift = above[p];
						e_kind = KIND_ACK;
						e_slot = slot_q;
					end else if (act_q == ACT_RESET_SLOT) begin
						e_slot = slot_q;
						if (slot_in_range) begin
							for (int p = 0; p < NUM_BUFFERS; p++) ctl[p].clr = posm_m[p];
							e_kind = KIND_FLUSH;
						end else begin
							e_kind = KIND_ACK;
						end
					end
				end
			end

			S_MISS: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_MISS;
					e_slot  = slot_to_out(entries[NUM_BUFFERS-1].slot);
					state_d = S_IDLE;
				end
			end

			S_LIST: begin
				if (out_free) begin
					emit = 1'b1;
					if (|list_q && cnt_q != CNT_W'(MAX_FLUSH)) begin
						pos         = first_set(list_q);
						e_kind      = KIND_FLUSH;
						e_slot      = slot_to_out(entries[pos].slot);
						e_last      = 1'b0;
						list_d[pos] = 1'b0;
						cnt_d       = cnt_q + CNT_W'(1);
					end else begin
						state_d = S_IDLE;
					end
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	// Command latch
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= req.action;
			rel_q  <= req.relation_id;
			page_q <= req.page_id;
			slot_q <= req.slot;
		end
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			list_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_ACK;
			slot_out_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			list_q  <= list_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				out_valid_q <= 1'b1;
				kind_q      <= e_kind;
				slot_out_q  <= e_slot;
				last_q      <= e_last;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.kind     = kind_q;
	assign rsp.slot_out = slot_out_q;
	assign rsp.last     = last_q;

	// A transaction always starts the evaluation step
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_RUN)
		else $error("accepted command did not enter evaluation");

	// Buffer indexes in the row stay unique, so a slot matches one position at most
	a_posm_unique: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> $onehot0(posm_m))
		else $error("slot found at more than one LRU position");

	// Tags of live buffers are unique, so a lookup hits one position at most
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && act_q == ACT_LOOKUP) |-> $onehot0(hit_m))
		else $error("lookup matched more than one buffer");

	// The flush walk never reports more than the cap
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LIST |-> cnt_q <= CNT_W'(MAX_FLUSH))
		else $error("flush count beyond cap");

endmodule

// File: src/lpbm_cell.sv
// ----------------------------------------------------------------------------
// lpbm_cell
// One LRU position: holds a buffer index and its tags, compares them with
// the incoming command, and on a shift takes its head-side neighbor's entry (the touched entry at the head).
// ----------------------------------------------------------------------------
module lpbm_cell import lpbm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slot_id_t             idx,
	input  cell_ctl_t            ctl,
	input  logic [REL_W-1:0]     req_rel,
	input  logic [PAGE_W-1:0]    req_page,
	input  logic [SLOT_IN_W-1:0] req_slot,
	input  entry_t               shift_in,
	input  logic [REL_W-1:0]     wr_rel,
	input  logic [PAGE_W-1:0]    wr_page,
	output entry_t               entry,
	output cell_flags_t          flags
);

	entry_t      entry_q;
	cell_flags_t flags_q;
	cell_flags_t flags_d;
	logic        is_free;

	// Compare against the command on the channel
	always_comb begin
		is_free       = (entry_q.rel == FREE_REL);
		flags_d.free  = is_free;
		flags_d.hit   = !is_free && (entry_q.rel == req_rel) && (entry_q.page == req_page);
		flags_d.relm  = (req_rel != FREE_REL) && (entry_q.rel == req_rel);
		flags_d.posm  = (CMP_W'(entry_q.slot) == CMP_W'(req_slot));
	end

	// Entry: shift from neighbor, tag write, or free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.slot <= idx;
			entry_q.rel  <= FREE_REL;
			entry_q.page <= FREE_PAGE;
		end else begin
			priority if (ctl.shift) begin
				entry_q <= shift_in;
			end else if (ctl.wr) begin
				entry_q.rel  <= wr_rel;
				entry_q.page <= wr_page;
			end else if (ctl.clr) begin
				entry_q.rel  <= FREE_REL;
				entry_q.page <= FREE_PAGE;
			end else begin
				entry_q <= entry_q;
			end
		end
	end

	// Compare flags, captured with the transaction
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			flags_q <= flags_d;
		end
	end

	assign entry = entry_q;
	assign flags = flags_q;

endmodule
